@@ design/demand_page_table_mapper_unit_macros.svh @@
// Assertion macros used by the page table mapper RTL.
`ifndef DEMAND_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`define DEMAND_PAGE_TABLE_MAPPER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DPT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DPT_ASSERT(label, prop, msg)
`define DPT_NEVER(label, cond, msg)
`endif
`endif

@@ design/dpt_pkg.sv @@
// Types, codes and defaults of the demand page table mapper.
package dpt_pkg;

  localparam int unsigned PoolPagesDef = 64;
  localparam int unsigned PageLimitDef = 16;
  localparam int unsigned TableEntries = 512;
  localparam int unsigned IdxW         = 9;
  localparam int unsigned PageBits     = 12;
  localparam int unsigned AddrW        = 48;

  localparam logic [5:0]  FscMask      = 6'h3f;
  localparam logic [5:0]  FscL3Trans   = 6'h07;
  localparam logic [47:0] PoolBaseRst  = 48'd0;
  localparam logic [63:0] TableFlagRst = 64'd3;
  localparam logic [63:0] PageFlagRst  = 64'd1795;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MAP   = 2'd2,
    CMD_FAULT = 2'd3
  } dpt_cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LIMIT  = 2'd1,
    ST_NOTTR  = 2'd2,
    ST_NOMEM  = 2'd3
  } dpt_status_e;

  typedef enum logic [1:0] {
    REG_POOL_BASE   = 2'd0,
    REG_TABLE_FLAGS = 2'd1,
    REG_PAGE_FLAGS  = 2'd2
  } dpt_reg_e;

  typedef enum logic [1:0] {
    PURP_CMD,
    PURP_FAULT,
    PURP_ROOT,
    PURP_TABLE
  } dpt_purp_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_ZERO,
    S_MAP_START,
    S_WALK_RD,
    S_WALK_EVAL,
    S_LINK,
    S_LEAF,
    S_RESP
  } dpt_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [47:0] virt_addr;
    logic [47:0] phys_addr;
    logic [5:0]  fault_status;
  } dpt_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] page_addr;
  } dpt_res_t;

endpackage

@@ design/dpt_table_ram.sv @@
// Single-port table entry memory with registered read data.
module dpt_table_ram #(
  parameter int unsigned AW = 15
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [63:0]   wdata_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

@@ design/dpt_page_pool.sv @@
// Busy bitmap of the physical page pool.
module dpt_page_pool #(
  parameter int unsigned POOL_PAGES = dpt_pkg::PoolPagesDef,
  parameter int unsigned PW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [PW-1:0] idx_i,
  input  logic          set_i,
  input  logic          clr_i,
  output logic          busy_o
);

  logic [POOL_PAGES-1:0] busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (set_i) begin
      busy_q[idx_i] <= 1'b1;
    end else if (clr_i) begin
      busy_q[idx_i] <= 1'b0;
    end
  end

  assign busy_o = busy_q[idx_i];

endmodule

@@ design/demand_page_table_mapper_unit.sv @@
// Top level of the demand page table mapper: command sequencer and registers.
//
// Requests enter on req_i when start is high and busy is low; busy stays
// high until the result has been shown. Each request yields one result on res_o,
// marked by res_valid_o for exactly one cycle; the receiver cannot stall it.
// Configuration is written through the APB port (64-bit registers at byte
// addresses 0, 8 and 16); the user must write it only while the block is idle,
// which the block itself does not enforce.
// An allocation scans the busy bitmap one page a cycle, zeroes the new page
// one entry a cycle through the single table memory port and answers in the
// cycle after. A map that needs no new table reads and checks one entry at
// each of the three upper table levels, then writes the leaf entry. A new
// root adds one allocation, each new lower table an allocation and a link
// write; a fault adds one allocation. The next request can be accepted in
// the cycle after the result.
// Reset clears the bitmap, the root pointer and both page counts at once; the
// table memory needs no clearing since every page is zeroed when allocated.
module demand_page_table_mapper_unit #(
  parameter int unsigned POOL_PAGES = dpt_pkg::PoolPagesDef,
  parameter int unsigned PAGE_LIMIT = dpt_pkg::PageLimitDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  dpt_pkg::dpt_req_t  req_i,
  output logic               res_valid_o,
  output dpt_pkg::dpt_res_t  res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned PW   = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
  localparam int unsigned AW   = PW + dpt_pkg::IdxW;
  localparam int unsigned CW   = $clog2(PAGE_LIMIT + 1);
  localparam int unsigned PNW  = 52;

  dpt_pkg::dpt_state_e state_q, state_d;
  dpt_pkg::dpt_purp_e  purp_q, purp_d;

  logic [47:0]   pool_base_q;
  logic [63:0]   tflags_q, pflags_q;
  logic [47:0]   va_q, va_d;
  logic [48:0]   pa_q, pa_d;
  logic [PW-1:0] scan_q, scan_d;
  logic [8:0]    zero_q, zero_d;
  logic [1:0]    lvl_q, lvl_d;
  logic [PNW-1:0] t_q, t_d;
  logic [48:0]   alloc_q, alloc_d;
  logic [48:0]   root_q, root_d;
  logic          root_v_q, root_v_d;
  logic [CW-1:0] tcnt_q, tcnt_d, mcnt_q, mcnt_d;
  logic [1:0]    status_q, status_d;
  logic [47:0]   page_q, page_d;
  logic          oob_q, oob_d;

  logic [PNW:0]  pdiff;
  logic          t_oob;
  logic [8:0]    lvl_idx;
  logic [48:0]   new_addr;
  logic          pool_busy, pool_set, pool_clr;
  logic [PW-1:0] pool_idx;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [63:0]   ram_wdata, ram_rdata;
  logic          cfg_wr;

  // Position of table page t_q inside the pool, with a borrow for pages below it.
  assign pdiff = {1'b0, t_q} - {17'd0, pool_base_q[47:dpt_pkg::PageBits]};
  assign t_oob = pdiff[PNW] || (pdiff[PNW-1:0] >= PNW'(POOL_PAGES));
  assign new_addr = {1'b0, pool_base_q} + {{(37-PW){1'b0}}, scan_q, 12'd0};

  always_comb begin
    case (lvl_q)
      2'd0:    lvl_idx = va_q[47:39];
      2'd1:    lvl_idx = va_q[38:30];
      2'd2:    lvl_idx = va_q[29:21];
      default: lvl_idx = va_q[20:12];
    endcase
  end

  dpt_page_pool #(.POOL_PAGES(POOL_PAGES), .PW(PW)) u_pool (
    .clk_i, .rst_ni, .idx_i(pool_idx), .set_i(pool_set), .clr_i(pool_clr),
    .busy_o(pool_busy)
  );

  dpt_table_ram #(.AW(AW)) u_ram (
    .clk_i, .we_i(ram_we), .re_i(ram_re), .addr_i(ram_addr),
    .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= dpt_pkg::PoolBaseRst;
      tflags_q    <= dpt_pkg::TableFlagRst;
      pflags_q    <= dpt_pkg::PageFlagRst;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        dpt_pkg::REG_POOL_BASE:   pool_base_q <= pwdata[47:0];
        dpt_pkg::REG_TABLE_FLAGS: tflags_q    <= pwdata;
        dpt_pkg::REG_PAGE_FLAGS:  pflags_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      dpt_pkg::REG_POOL_BASE:   prdata = {16'd0, pool_base_q};
      dpt_pkg::REG_TABLE_FLAGS: prdata = tflags_q;
      dpt_pkg::REG_PAGE_FLAGS:  prdata = pflags_q;
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dpt_pkg::S_IDLE;
      root_v_q <= 1'b0;
      root_q   <= '0;
      tcnt_q   <= '0;
      mcnt_q   <= '0;
    end else begin
      state_q  <= state_d;
      root_v_q <= root_v_d;
      root_q   <= root_d;
      tcnt_q   <= tcnt_d;
      mcnt_q   <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    purp_q   <= purp_d;
    va_q     <= va_d;
    pa_q     <= pa_d;
    scan_q   <= scan_d;
    zero_q   <= zero_d;
    lvl_q    <= lvl_d;
    t_q      <= t_d;
    alloc_q  <= alloc_d;
    status_q <= status_d;
    page_q   <= page_d;
    oob_q    <= oob_d;
  end

  always_comb begin
    state_d  = state_q;
    purp_d   = purp_q;
    va_d     = va_q;
    pa_d     = pa_q;
    scan_d   = scan_q;
    zero_d   = zero_q;
    lvl_d    = lvl_q;
    t_d      = t_q;
    alloc_d  = alloc_q;
    root_d   = root_q;
    root_v_d = root_v_q;
    tcnt_d   = tcnt_q;
    mcnt_d   = mcnt_q;
    status_d = status_q;
    page_d   = page_q;
    oob_d    = oob_q;
    pool_idx = scan_q;
    pool_set = 1'b0;
    pool_clr = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = {pdiff[PW-1:0], lvl_idx};
    ram_wdata = '0;

    unique case (state_q)
      dpt_pkg::S_IDLE: begin
        if (start) begin
          status_d = dpt_pkg::ST_OK;
          page_d   = '0;
          va_d     = req_i.virt_addr;
          pa_d     = {1'b0, req_i.phys_addr};
          scan_d   = '0;
          unique case (req_i.command)
            dpt_pkg::CMD_ALLOC: begin
              purp_d  = dpt_pkg::PURP_CMD;
              state_d = dpt_pkg::S_SCAN;
            end
            dpt_pkg::CMD_FREE: begin
              t_d     = {16'd0, req_i.phys_addr[47:dpt_pkg::PageBits]};
              state_d = dpt_pkg::S_FREE;
            end
            dpt_pkg::CMD_MAP: begin
              state_d = dpt_pkg::S_MAP_START;
            end
            default: begin
              if ((req_i.fault_status & dpt_pkg::FscMask) != dpt_pkg::FscL3Trans) begin
                status_d = dpt_pkg::ST_NOTTR;
                state_d  = dpt_pkg::S_RESP;
              end else begin
                purp_d  = dpt_pkg::PURP_FAULT;
                state_d = dpt_pkg::S_SCAN;
              end
            end
          endcase
        end
      end
      dpt_pkg::S_FREE: begin
        pool_idx = pdiff[PW-1:0];
        pool_clr = !t_oob;
        state_d  = dpt_pkg::S_RESP;
      end
      dpt_pkg::S_SCAN: begin
        if (!pool_busy) begin
          pool_set = 1'b1;
          zero_d   = '0;
          state_d  = dpt_pkg::S_ZERO;
        end else if (scan_q == PW'(POOL_PAGES - 1)) begin
          status_d = dpt_pkg::ST_NOMEM;
          state_d  = dpt_pkg::S_RESP;
        end else begin
          scan_d = scan_q + PW'(1);
        end
      end
      dpt_pkg::S_ZERO: begin
        ram_we   = 1'b1;
        ram_addr = {scan_q, zero_q};
        zero_d   = zero_q + 9'd1;
        if (zero_q == 9'(dpt_pkg::TableEntries - 1)) begin
          alloc_d = new_addr;
          unique case (purp_q)
            dpt_pkg::PURP_CMD: begin
              page_d  = new_addr[47:0];
              state_d = dpt_pkg::S_RESP;
            end
            dpt_pkg::PURP_FAULT: begin
              page_d  = new_addr[47:0];
              pa_d    = new_addr;
              va_d    = {va_q[47:12], 12'd0};
              state_d = dpt_pkg::S_MAP_START;
            end
            dpt_pkg::PURP_ROOT: begin
              root_d   = new_addr;
              root_v_d = 1'b1;
              tcnt_d   = tcnt_q + CW'(1);
              t_d      = {15'd0, new_addr[48:12]};
              lvl_d    = 2'd0;
              state_d  = dpt_pkg::S_WALK_RD;
            end
            default: state_d = dpt_pkg::S_LINK;
          endcase
        end
      end
      dpt_pkg::S_MAP_START: begin
        lvl_d = 2'd0;
        if (root_v_q) begin
          t_d     = {15'd0, root_q[48:12]};
          state_d = dpt_pkg::S_WALK_RD;
        end else if (tcnt_q >= CW'(PAGE_LIMIT)) begin
          status_d = dpt_pkg::ST_LIMIT;
          state_d  = dpt_pkg::S_RESP;
        end else begin
          purp_d  = dpt_pkg::PURP_ROOT;
          scan_d  = '0;
          state_d = dpt_pkg::S_SCAN;
        end
      end
      dpt_pkg::S_WALK_RD: begin
        // A table page outside the pool reads as all-zero entries.
        ram_re  = !t_oob;
        oob_d   = t_oob;
        state_d = dpt_pkg::S_WALK_EVAL;
      end
      dpt_pkg::S_WALK_EVAL: begin
        if (oob_q || ram_rdata == 64'd0) begin
          if (tcnt_q >= CW'(PAGE_LIMIT)) begin
            status_d = dpt_pkg::ST_LIMIT;
            state_d  = dpt_pkg::S_RESP;
          end else begin
            purp_d  = dpt_pkg::PURP_TABLE;
            scan_d  = '0;
            state_d = dpt_pkg::S_SCAN;
          end
        end else begin
          t_d   = ram_rdata[63:12];
          lvl_d = lvl_q + 2'd1;
          state_d = (lvl_q == 2'd2) ? dpt_pkg::S_LEAF : dpt_pkg::S_WALK_RD;
        end
      end
      dpt_pkg::S_LINK: begin
        ram_we    = !t_oob;
        ram_wdata = {15'd0, alloc_q} | tflags_q;
        tcnt_d    = tcnt_q + CW'(1);
        t_d       = {15'd0, alloc_q[48:12]};
        lvl_d     = lvl_q + 2'd1;
        state_d   = (lvl_q == 2'd2) ? dpt_pkg::S_LEAF : dpt_pkg::S_WALK_RD;
      end
      dpt_pkg::S_LEAF: begin
        // The leaf entry is written even when the mapped page count is full.
        ram_we    = !t_oob;
        ram_wdata = {15'd0, pa_q} | pflags_q;
        if (mcnt_q >= CW'(PAGE_LIMIT)) begin
          status_d = dpt_pkg::ST_LIMIT;
        end else begin
          mcnt_d   = mcnt_q + CW'(1);
          status_d = dpt_pkg::ST_OK;
        end
        state_d = dpt_pkg::S_RESP;
      end
      dpt_pkg::S_RESP: begin
        state_d = dpt_pkg::S_IDLE;
      end
      default: state_d = dpt_pkg::S_IDLE;
    endcase
  end

  assign busy         = (state_q != dpt_pkg::S_IDLE);
  assign res_valid_o  = (state_q == dpt_pkg::S_RESP);
  assign res_o.status    = status_q;
  assign res_o.page_addr = page_q;

`include "demand_page_table_mapper_unit_macros.svh"

  `DPT_ASSERT(a_res_one_cycle, res_valid_o |=> !res_valid_o, "result strobe longer than a cycle")
  `DPT_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `DPT_NEVER(a_tcnt_limit, tcnt_q > CW'(PAGE_LIMIT), "table page count above limit")
  `DPT_NEVER(a_mcnt_limit, mcnt_q > CW'(PAGE_LIMIT), "mapped page count above limit")

endmodule
